### rtl/core/afk3y_pkg.sv
// Package with constants and sine helpers for the three-link arm kinematics pipeline.
package afk3y_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int LENGTH_BITS_DEF    = 16;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    localparam int COORD_W = 19;
    localparam int DIST_W  = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINK1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK3 = 2'd2;

    localparam logic [17:0] POLY_A = 18'd102944;
    localparam logic [17:0] POLY_B = 18'd42048;
    localparam logic [17:0] POLY_C = 18'd4640;

    // Folds a quadrant fraction into the Q16 polynomial argument x (0..65536).
    function automatic logic [16:0] sin_arg(input logic q0, input logic [16:0] xq);
        logic [16:0] r;
        r = q0 ? (17'd65536 - xq) : xq;
        return r;
    endfunction

endpackage

### rtl/core/afk3y_sqrt_stage.sv
// One restoring step of the pipelined integer square root.
module afk3y_sqrt_stage #(
    parameter int RW = 18,
    parameter int NW = 38,
    parameter int STEP = 0
) (
    input  logic [NW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    output logic [NW-1:0] o_rem,
    output logic [RW-1:0] o_root
);
    localparam int SH = 2 * (RW - 1 - STEP);
    logic [NW-1:0] w_trial;
    logic [NW-1:0] w_cmp;

    assign w_trial = ({{(NW-RW){1'b0}}, i_root} << (SH + 2)) |
                     ({{(NW-1){1'b0}}, 1'b1} << SH);
    assign w_cmp   = w_trial;

    always_comb begin
        if (i_rem >= w_cmp) begin
            o_rem  = i_rem - w_cmp;
            o_root = (i_root << 1) | {{(RW-1){1'b0}}, 1'b1};
        end else begin
            o_rem  = i_rem;
            o_root = i_root << 1;
        end
    end
endmodule

### rtl/core/arm_forward_kinematics_3link_yaw_top.sv
// Top level of the pipelined three-link arm forward kinematics with base yaw.
// Each request carries a base yaw and three absolute link elevations as binary angles
// (a full turn is 2^ANGLE_BITS). The block computes the horizontal reach
// H = sum(len_i * cos(elev_i)), z = sum(len_i * sin(elev_i)) rounded half up, then
// x = H*cos(yaw) and y = H*sin(yaw) rounded half up, and the distance from the origin
// rounded to nearest. Sine and cosine come from an odd polynomial evaluated over
// five registered stages: the quadrant fold, then one multiplier in each of the next
// four, the last of which also rounds and signs the value. The distance is a pipelined
// restoring square root with one root bit per register stage, DIST_W+1 stages in all.
// One request is accepted every clock cycle unless the output stalls. The pipeline has
// 5 trig stages, 2 product stages, 2 yaw scaling stages, 2 squaring stages and DIST_W+1
// root stages plus the rounding stage. The whole pipeline advances only when the output
// register is free or being taken, so a stall holds every stage. The user must write
// link lengths with i_cfg_we only while no request is in flight; the block itself
// does not enforce this.
module arm_forward_kinematics_3link_yaw_top #(
    parameter int ANGLE_BITS     = afk3y_pkg::ANGLE_BITS_DEF,
    parameter int LENGTH_BITS    = afk3y_pkg::LENGTH_BITS_DEF,
    parameter int TRIG_FRAC_BITS = afk3y_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [afk3y_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [LENGTH_BITS-1:0]                i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [ANGLE_BITS-1:0]          i_base_yaw,
    input  logic signed [ANGLE_BITS-1:0]          i_elev_one,
    input  logic signed [ANGLE_BITS-1:0]          i_elev_two,
    input  logic signed [ANGLE_BITS-1:0]          i_elev_three,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [afk3y_pkg::COORD_W-1:0]  o_pos_x,
    output logic signed [afk3y_pkg::COORD_W-1:0]  o_pos_y,
    output logic signed [afk3y_pkg::COORD_W-1:0]  o_pos_z,
    output logic [afk3y_pkg::DIST_W-1:0]          o_reach_dist
);
    localparam int F   = TRIG_FRAC_BITS;
    localparam int FB  = ANGLE_BITS - 2;
    localparam int TW  = F + 2;                 // signed trig value width
    localparam int PW  = LENGTH_BITS + TW + 2;  // sum of three len*trig products
    localparam int XW  = PW + TW;               // H*trig product
    localparam int CW  = afk3y_pkg::COORD_W;
    localparam int DW  = afk3y_pkg::DIST_W;
    localparam int RW  = DW + 1;                // root before rounding/saturation
    localparam int NW  = 2 * RW;                // radicand width
    localparam int SW  = 2 * CW + 2;            // sum of squares width
    localparam int NT  = 8;                     // trig lanes: sin/cos of 4 angles
    localparam int NSQ = RW;                    // one root bit per stage

    // Pipeline control: every stage moves when the output slot can accept.
    localparam int NST = 5 + 2 + 2 + 2 + NSQ + 1;
    logic         w_adv;
    logic [NST-1:0] r_vld;

    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[NST-1];

    // Configuration registers.
    logic [LENGTH_BITS-1:0] r_len1, r_len2, r_len3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= '0;
            r_len2 <= '0;
            r_len3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                afk3y_pkg::REG_LINK1: r_len1 <= i_cfg_data;
                afk3y_pkg::REG_LINK2: r_len2 <= i_cfg_data;
                afk3y_pkg::REG_LINK3: r_len3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Trig stage 1: phase to polynomial argument. Lane 2k is sin, 2k+1 is cos.
    logic [ANGLE_BITS-1:0] w_ang [4];
    assign w_ang[0] = i_base_yaw;
    assign w_ang[1] = i_elev_one;
    assign w_ang[2] = i_elev_two;
    assign w_ang[3] = i_elev_three;

    logic [16:0] r_t1_x [NT];
    logic        r_t1_neg [NT];
    logic [16:0] r_t2_x [NT];
    logic [16:0] r_t2_x2 [NT];
    logic        r_t2_neg [NT];
    logic [16:0] r_t3_x [NT];
    logic [17:0] r_t3_t [NT];
    logic [16:0] r_t3_x2 [NT];
    logic        r_t3_neg [NT];
    logic [16:0] r_t4_x [NT];
    logic [17:0] r_t4_t [NT];
    logic        r_t4_neg [NT];
    logic signed [TW-1:0] w_trig [NT];
    logic signed [TW-1:0] r_t5_trig [NT];

    for (genvar g = 0; g < NT; g++) begin : g_trig
        logic [ANGLE_BITS-1:0] w_ph;
        logic [1:0]  w_q;
        logic [16:0] w_xq;
        logic [33:0] w_sq;
        logic [34:0] w_m1;
        logic [34:0] w_m2;
        logic [34:0] w_m3;
        logic [16:0] w_s;
        logic [TW-2:0] w_mag;

        assign w_ph = w_ang[g/2] + ((g % 2 == 1) ?
                      (ANGLE_BITS'(1) << FB) : ANGLE_BITS'(0));
        assign w_q  = w_ph[ANGLE_BITS-1 -: 2];
        if (FB >= 16) begin : g_rs
            assign w_xq = {1'b0, w_ph[FB-1 -: 16]};
        end else begin : g_ls
            assign w_xq = 17'(w_ph[FB-1:0]) << (16 - FB);
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_t1_x[g]   <= afk3y_pkg::sin_arg(w_q[0], w_xq);
                r_t1_neg[g] <= w_q[1];
            end
        end

        assign w_sq = r_t1_x[g] * r_t1_x[g];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_t2_x[g]   <= r_t1_x[g];
                r_t2_x2[g]  <= w_sq[32:16];
                r_t2_neg[g] <= r_t1_neg[g];
            end
        end

        assign w_m1 = r_t2_x2[g] * afk3y_pkg::POLY_C;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_t3_x[g]   <= r_t2_x[g];
                r_t3_x2[g]  <= r_t2_x2[g];
                r_t3_t[g]   <= afk3y_pkg::POLY_B - 18'(w_m1[34:16]);
                r_t3_neg[g] <= r_t2_neg[g];
            end
        end

        assign w_m2 = r_t3_x2[g] * r_t3_t[g];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_t4_x[g]   <= r_t3_x[g];
                r_t4_t[g]   <= afk3y_pkg::POLY_A - 18'(w_m2[34:16]);
                r_t4_neg[g] <= r_t3_neg[g];
            end
        end

        assign w_m3 = r_t4_x[g] * r_t4_t[g];
        assign w_s  = w_m3[32:16];
        if (F >= 16) begin : g_up
            assign w_mag = (TW-1)'({w_s} << (F - 16));
        end else begin : g_dn
            localparam int SH = 16 - F;
            logic [17:0] w_rnd;
            assign w_rnd = {1'b0, w_s} + (18'(1) << (SH - 1));
            assign w_mag = (TW-1)'(w_rnd >> SH);
        end
        assign w_trig[g] = r_t4_neg[g] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

        // The finished trig value is registered so the length products start fresh.
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_t5_trig[g] <= w_trig[g];
            end
        end
    end

    // Product stage: len_i * trig_i for the elevations, registered.
    localparam int LPW = LENGTH_BITS + TW + 1;
    logic signed [LPW-1:0] r_pc [3];
    logic signed [LPW-1:0] r_ps [3];
    logic signed [TW-1:0]  r_p_ys, r_p_yc;
    logic [LENGTH_BITS-1:0] w_len [3];
    assign w_len[0] = r_len1;
    assign w_len[1] = r_len2;
    assign w_len[2] = r_len3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_pc[k] <= $signed({1'b0, w_len[k]}) * r_t5_trig[2*k+3];
                r_ps[k] <= $signed({1'b0, w_len[k]}) * r_t5_trig[2*k+2];
            end
            r_p_ys <= r_t5_trig[0];
            r_p_yc <= r_t5_trig[1];
        end
    end

    // Sum stage: horizontal reach and z.
    logic signed [PW-1:0] r_h;
    logic signed [CW-1:0] r_s_z;
    logic signed [TW-1:0] r_s_ys, r_s_yc;
    logic signed [PW-1:0] w_v;
    logic signed [PW-1:0] w_vr;
    assign w_v  = PW'(r_ps[0]) + PW'(r_ps[1]) + PW'(r_ps[2]);
    assign w_vr = (w_v + (PW'(1) <<< (F - 1))) >>> F;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h    <= PW'(r_pc[0]) + PW'(r_pc[1]) + PW'(r_pc[2]);
            r_s_z  <= CW'(w_vr);
            r_s_ys <= r_p_ys;
            r_s_yc <= r_p_yc;
        end
    end

    // Yaw scaling: full products, then round by 2F.
    logic signed [XW-1:0] r_xp, r_yp;
    logic signed [CW-1:0] r_y1_z;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xp   <= XW'(r_h) * XW'(r_s_yc);
            r_yp   <= XW'(r_h) * XW'(r_s_ys);
            r_y1_z <= r_s_z;
        end
    end

    logic signed [XW-1:0] w_xr, w_yr;
    assign w_xr = (r_xp + (XW'(1) <<< (2*F - 1))) >>> (2*F);
    assign w_yr = (r_yp + (XW'(1) <<< (2*F - 1))) >>> (2*F);

    logic signed [CW-1:0] r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x <= CW'(w_xr);
            r_y <= CW'(w_yr);
            r_z <= r_y1_z;
        end
    end

    // Squares, then their sum.
    logic [2*CW-1:0] r_sx, r_sy, r_sz;
    logic signed [CW-1:0] r_q_x, r_q_y, r_q_z;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx  <= (2*CW)'(r_x * r_x);
            r_sy  <= (2*CW)'(r_y * r_y);
            r_sz  <= (2*CW)'(r_z * r_z);
            r_q_x <= r_x;
            r_q_y <= r_y;
            r_q_z <= r_z;
        end
    end

    logic [SW-1:0] r_n;
    logic signed [CW-1:0] r_n_x, r_n_y, r_n_z;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n   <= SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
            r_n_x <= r_q_x;
            r_n_y <= r_q_y;
            r_n_z <= r_q_z;
        end
    end

    // Square root, one bit per stage.
    logic [NW-1:0] r_rem  [NSQ+1];
    logic [RW-1:0] r_root [NSQ+1];
    logic signed [CW-1:0] r_cx [NSQ+1];
    logic signed [CW-1:0] r_cy [NSQ+1];
    logic signed [CW-1:0] r_cz [NSQ+1];

    assign r_rem[0]  = NW'(r_n);
    assign r_root[0] = '0;
    assign r_cx[0]   = r_n_x;
    assign r_cy[0]   = r_n_y;
    assign r_cz[0]   = r_n_z;

    for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
        logic [NW-1:0] w_rem;
        logic [RW-1:0] w_root;
        afk3y_sqrt_stage #(.RW(RW), .NW(NW), .STEP(s)) u_step (
            .i_rem  (r_rem[s]),
            .i_root (r_root[s]),
            .o_rem  (w_rem),
            .o_root (w_root)
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[s+1]  <= w_rem;
                r_root[s+1] <= w_root;
                r_cx[s+1]   <= r_cx[s];
                r_cy[s+1]   <= r_cy[s];
                r_cz[s+1]   <= r_cz[s];
            end
        end
    end

    // Round to nearest: remainder n - r^2 greater than r means bump.
    logic [RW:0] w_rd;
    assign w_rd = (r_rem[NSQ] > NW'(r_root[NSQ])) ? ({1'b0, r_root[NSQ]} + 1'b1)
                                                   : {1'b0, r_root[NSQ]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_pos_x      <= r_cx[NSQ];
            o_pos_y      <= r_cy[NSQ];
            o_pos_z      <= r_cz[NSQ];
            o_reach_dist <= (w_rd > (RW+1)'({DW{1'b1}})) ? {DW{1'b1}} : DW'(w_rd);
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_reach_dist) && $stable(o_pos_x)))
        else $error("output changed during stall");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline not ready with empty output");
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pos_x == '0 && o_pos_y == '0 && o_pos_z == '0) |-> o_reach_dist == '0)
        else $error("nonzero distance at origin");
`endif
endmodule

### tb/arm_forward_kinematics_3link_yaw_top_tb.sv
// Self-checking testbench for the three-link arm forward kinematics block with base yaw.
`timescale 1ns / 1ps

module arm_forward_kinematics_3link_yaw_top_tb;

    // The pipeline is 31 stages deep, so DRAIN_CYCLES covers any request still in flight.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 120;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        logic signed [afk3y_pkg::COORD_W-1:0] x;
        logic signed [afk3y_pkg::COORD_W-1:0] y;
        logic signed [afk3y_pkg::COORD_W-1:0] z;
        logic [afk3y_pkg::DIST_W-1:0]         d;
    } t_pose;

    // One row of the directed table: either a register write or a request.
    // Rows with known set carry an expected pose that is read straight off the math.
    typedef struct {
        t_row_kind                       kind;
        logic [afk3y_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                     data;
        logic [15:0]                     yaw, e1, e2, e3;
        bit                              known;
        t_pose                           want;
    } t_dir_row;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [afk3y_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [15:0] i_base_yaw, i_elev_one, i_elev_two, i_elev_three;
    logic signed [afk3y_pkg::COORD_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [afk3y_pkg::DIST_W-1:0] o_reach_dist;

    arm_forward_kinematics_3link_yaw_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_base_yaw(i_base_yaw), .i_elev_one(i_elev_one),
        .i_elev_two(i_elev_two), .i_elev_three(i_elev_three),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_reach_dist(o_reach_dist)
    );

    // Our own copy of the link length registers.
    longint len_one, len_two, len_three;

    t_pose pending_poses[$];
    int    error_count;
    int    cycle_count;
    bit    calm;          // when set, neither side idles
    bit    next_known;
    t_pose next_want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Polynomial sine of a binary angle, returned as a signed Q1.15 value.
    function automatic longint sin_q15(logic [15:0] ph);
        longint x, x2, t, s;
        x = longint'(ph[13:0]) << 2;
        if (ph[14]) x = 65536 - x;
        x2 = (x * x) >> 16;
        t = 42048 - ((x2 * 4640) >> 16);
        t = 102944 - ((x2 * t) >> 16);
        s = (x * t) >> 16;
        s = (s + 1) >> 1;
        return ph[15] ? -s : s;
    endfunction

    function automatic longint cos_q15(logic [15:0] ph);
        return sin_q15(ph + 16'h4000);
    endfunction

    // Integer square root rounded to nearest.
    function automatic longint root_nearest(longint n);
        longint r, b, rem;
        r = 0;
        b = 64'sd1 << 62;
        rem = n;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n - r * r > r) r++;
        return r;
    endfunction

    function automatic t_pose predict_pose(logic [15:0] yaw, logic [15:0] e1,
                                           logic [15:0] e2, logic [15:0] e3);
        longint h, v, x, y, z, d;
        t_pose p;
        h = len_one * cos_q15(e1) + len_two * cos_q15(e2) + len_three * cos_q15(e3);
        v = len_one * sin_q15(e1) + len_two * sin_q15(e2) + len_three * sin_q15(e3);
        // Round half up; >>> floors on a signed value.
        x = (h * cos_q15(yaw) + (64'sd1 << 29)) >>> 30;
        y = (h * sin_q15(yaw) + (64'sd1 << 29)) >>> 30;
        z = (v + 16384) >>> 15;
        d = root_nearest(x * x + y * y + z * z);
        if (d > (1 << afk3y_pkg::DIST_W) - 1) d = (1 << afk3y_pkg::DIST_W) - 1;
        p.x = x[afk3y_pkg::COORD_W-1:0];
        p.y = y[afk3y_pkg::COORD_W-1:0];
        p.z = z[afk3y_pkg::COORD_W-1:0];
        p.d = d[afk3y_pkg::DIST_W-1:0];
        return p;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", field, got, want, cycle_count);
        error_count++;
    endtask

    // Request side: an accepted request queues its expected pose, taken from
    // the table when the row has one, otherwise from the predictor.
    // Result side: every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                pending_poses.push_back(next_known ? next_want :
                    predict_pose(i_base_yaw, i_elev_one, i_elev_two, i_elev_three));
            if (o_valid && i_ready) begin
                if (pending_poses.size() == 0) begin
                    report_mismatch("unexpected result, reach_dist", o_reach_dist, 0);
                end else begin
                    t_pose w;
                    w = pending_poses.pop_front();
                    if (o_pos_x !== w.x) report_mismatch("pos_x", o_pos_x, w.x);
                    if (o_pos_y !== w.y) report_mismatch("pos_y", o_pos_y, w.y);
                    if (o_pos_z !== w.z) report_mismatch("pos_z", o_pos_z, w.z);
                    if (o_reach_dist !== w.d) report_mismatch("reach_dist", o_reach_dist, w.d);
                end
            end
        end
    end

    // Result-side backpressure: about 8 stalls in a hundred, none while calm.
    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("arm_forward_kinematics_3link_yaw_top verification failed");
            $finish;
        end
    end

    // Presents one request at the falling edge and holds it until accepted.
    // A random gap with valid low may come first, before about 3 requests in a hundred
    // and never while calm.
    task automatic send_request(logic [15:0] yaw, logic [15:0] e1, logic [15:0] e2,
                                logic [15:0] e3, bit known, t_pose want);
        if (!calm && $urandom_range(99) < 3) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_base_yaw   <= yaw;
        i_elev_one   <= e1;
        i_elev_two   <= e2;
        i_elev_three <= e3;
        next_known   <= known;
        next_want    <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Waits until every expected result is back and the pipeline is empty,
    // then writes one register. Registers only change while the block is idle.
    task automatic write_length(logic [afk3y_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_poses.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            afk3y_pkg::REG_LINK1: len_one   = data;
            afk3y_pkg::REG_LINK2: len_two   = data;
            afk3y_pkg::REG_LINK3: len_three = data;
            default: ;  // writes past the third register are ignored
        endcase
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h4000;
            2: return 16'h8000;
            3: return 16'hC000;
            4: return 16'h7FFF;
            5: return 16'(16'h3FFF + $urandom_range(2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    t_dir_row dir_rows[$];

    function automatic t_dir_row item_row(logic [15:0] yaw, logic [15:0] e1, logic [15:0] e2,
                                          logic [15:0] e3, bit known, t_pose want);
        t_dir_row r;
        r.kind = ROW_ITEM; r.idx = afk3y_pkg::REG_LINK1; r.data = 16'h0000;
        r.yaw = yaw; r.e1 = e1; r.e2 = e2; r.e3 = e3;
        r.known = known; r.want = want;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [afk3y_pkg::CFG_IDX_W-1:0] idx,
                                         logic [15:0] data);
        t_dir_row r;
        r = item_row(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, '0);
        r.kind = ROW_CFG; r.idx = idx; r.data = data;
        return r;
    endfunction

    initial begin
        t_pose none;
        t_pose full_reach;
        none = '0;
        full_reach = '{x: 19'sd196605, y: 19'sd0, z: 19'sd0, d: 18'd196605};

        // Directed table. With all lengths zero after reset, every pose is the origin.
        dir_rows.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, none));
        dir_rows.push_back(item_row(16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 1'b1, none));
        // All links at full length, everything level: the arm stretches along x.
        dir_rows.push_back(cfg_row(afk3y_pkg::REG_LINK1, 16'hFFFF));
        dir_rows.push_back(cfg_row(afk3y_pkg::REG_LINK2, 16'hFFFF));
        dir_rows.push_back(cfg_row(afk3y_pkg::REG_LINK3, 16'hFFFF));
        dir_rows.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, full_reach));
        // Quadrant boundaries and extreme angles on every field.
        dir_rows.push_back(item_row(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0, none));
        dir_rows.push_back(item_row(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, none));
        dir_rows.push_back(item_row(16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b0, none));
        dir_rows.push_back(item_row(16'h0000, 16'h4000, 16'h4000, 16'h4000, 1'b0, none));
        dir_rows.push_back(item_row(16'h0000, 16'hC000, 16'hC000, 16'hC000, 1'b0, none));
        dir_rows.push_back(item_row(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, none));
        dir_rows.push_back(item_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, none));
        dir_rows.push_back(item_row(16'h2000, 16'h2000, 16'hE000, 16'h6000, 1'b0, none));
        dir_rows.push_back(item_row(16'h3FFF, 16'h4001, 16'hBFFF, 16'h0001, 1'b0, none));
        // A write to the unused register index must leave the lengths alone.
        dir_rows.push_back(cfg_row(2'd3, 16'h1234));
        dir_rows.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, full_reach));
        // Unequal links, one of them zero.
        dir_rows.push_back(cfg_row(afk3y_pkg::REG_LINK2, 16'h0000));
        dir_rows.push_back(cfg_row(afk3y_pkg::REG_LINK3, 16'h0123));
        dir_rows.push_back(item_row(16'h1555, 16'h0AAA, 16'h9999, 16'h5555, 1'b0, none));
        dir_rows.push_back(item_row(16'hF000, 16'hFFFF, 16'h0000, 16'h8001, 1'b0, none));

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = afk3y_pkg::REG_LINK1;
        i_cfg_data = 16'h0000;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_base_yaw = '0;
        i_elev_one = '0;
        i_elev_two = '0;
        i_elev_three = '0;
        next_known = 1'b0;
        next_want = '0;
        calm = 1'b0;
        error_count = 0;
        cycle_count = 0;
        len_one = 0;
        len_two = 0;
        len_three = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_length(dir_rows[k].idx, dir_rows[k].data);
            else
                send_request(dir_rows[k].yaw, dir_rows[k].e1, dir_rows[k].e2,
                             dir_rows[k].e3, dir_rows[k].known, dir_rows[k].want);
        end

        // Random phases, each under fresh link lengths. The last phase keeps the
        // maximum lengths, the first one uses the lengths one, zero and one.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_length(afk3y_pkg::REG_LINK1, ph == 0 ? 16'h0001
                         : ph == RAND_PHASES-1 ? 16'hFFFF : pick_length());
            write_length(afk3y_pkg::REG_LINK2, ph == 0 ? 16'h0000
                         : ph == RAND_PHASES-1 ? 16'hFFFF : pick_length());
            write_length(afk3y_pkg::REG_LINK3, ph == 0 ? 16'h0001
                         : ph == RAND_PHASES-1 ? 16'hFFFF : pick_length());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // A stretch in the middle of phase three runs with no idling at all.
                calm = (ph == 3 && n >= 20 && n < 90);
                send_request(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                             1'b0, '0);
            end
            calm = 1'b0;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_poses.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("arm_forward_kinematics_3link_yaw_top verification clean");
        end else begin
            $display("arm_forward_kinematics_3link_yaw_top verification failed");
        end
        $finish;
    end

endmodule

### arm_forward_kinematics_3link_yaw_top.f
rtl/core/afk3y_pkg.sv
rtl/core/afk3y_sqrt_stage.sv
rtl/core/arm_forward_kinematics_3link_yaw_top.sv
tb/arm_forward_kinematics_3link_yaw_top_tb.sv
